// ===== src/vdr3_pkg.sv =====
package vdr3_pkg;

  // Code and message geometry
  localparam int MSG_BITS = 8;
  localparam int GRP_BITS = 3;
  localparam int CW_W     = GRP_BITS * MSG_BITS;
  localparam int NST      = 4;
  localparam int ST_W     = 2;
  localparam int MET_W    = $clog2(CW_W + 1);
  localparam int PATH_W   = MSG_BITS;

  typedef logic [CW_W-1:0]     cw_t;
  typedef logic [MET_W-1:0]    met_t;
  typedef logic [PATH_W-1:0]   path_t;
  typedef logic [GRP_BITS-1:0] grp_t;

  // Per-state survivor information carried from cell to cell
  typedef struct packed {
    logic [NST-1:0]  reached;
    met_t [NST-1:0]  metric;
    path_t [NST-1:0] path;
  } trel_t;

  // Hamming distance between two 3-bit groups
  function automatic logic [1:0] grp_dist(input grp_t a, input grp_t b);
    grp_t d;
    d = a ^ b;
    return {1'b0, d[0]} + {1'b0, d[1]} + {1'b0, d[2]};
  endfunction

endpackage

// ===== src/vdr3_in_if.sv =====
interface vdr3_in_if;
  import vdr3_pkg::*;

  logic valid;
  logic ready;
  cw_t  codeword;

  modport source (output valid, output codeword, input ready);
  modport sink (input valid, input codeword, output ready);
endinterface

// ===== src/vdr3_out_if.sv =====
interface vdr3_out_if;
  import vdr3_pkg::*;

  logic  valid;
  logic  ready;
  path_t decoded_bits;
  met_t  error_count;

  modport source (output valid, output decoded_bits, output error_count, input ready);
  modport sink (input valid, input decoded_bits, input error_count, output ready);
endinterface

// ===== src/vdr3_cell.sv =====
module vdr3_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  vdr3_pkg::cw_t   up_cw,
  input  vdr3_pkg::trel_t up_trel,
  output logic            dn_valid,
  input  logic            dn_ready,
  output vdr3_pkg::cw_t   dn_cw,
  output vdr3_pkg::trel_t dn_trel
);
  import vdr3_pkg::*;

  logic   valid_r;
  cw_t    cw_r;
  trel_t  trel_r;
  trel_t  trel_nxt;
  grp_t   rx;

  assign rx       = up_cw[CW_W-1 -: GRP_BITS];
  assign up_ready = !valid_r || dn_ready;

  // Add-compare-select for every next state from its two predecessors
  always_comb begin
    logic [ST_W-1:0] ns;
    logic [ST_W-1:0] p0;
    logic [ST_W-1:0] p1;
    logic            b;
    logic            r1;
    met_t            m0;
    met_t            m1;
    trel_nxt = '0;
    for (int k = 0; k < NST; k++) begin
      ns = ST_W'(k);
      b  = ns[1];
      r1 = ns[0];
      p0 = {r1, 1'b0};
      p1 = {r1, 1'b1};
      m0 = up_trel.metric[p0] + MET_W'(grp_dist({r1 ^ b, b, r1 ^ b}, rx));
      m1 = up_trel.metric[p1] + MET_W'(grp_dist({r1 ^ b, !b, r1 ^ b}, rx));
      if (up_trel.reached[p0] && (!up_trel.reached[p1] || m0 <= m1)) begin
        trel_nxt.reached[ns] = 1'b1;
        trel_nxt.metric[ns]  = m0;
        trel_nxt.path[ns]    = {up_trel.path[p0][PATH_W-2:0], b};
      end else if (up_trel.reached[p1]) begin
        trel_nxt.reached[ns] = 1'b1;
        trel_nxt.metric[ns]  = m1;
        trel_nxt.path[ns]    = {up_trel.path[p1][PATH_W-2:0], b};
      end
    end
  end

  // Track occupancy of the stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // Load survivors and advance the codeword by one group
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      trel_r <= trel_nxt;
      cw_r   <= up_cw << GRP_BITS;
    end
  end

  assign dn_valid = valid_r;
  assign dn_cw    = cw_r;
  assign dn_trel  = trel_r;

endmodule

// ===== src/vdr3_select.sv =====
module vdr3_select (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  vdr3_pkg::trel_t up_trel,
  output logic            dn_valid,
  input  logic            dn_ready,
  output vdr3_pkg::path_t dn_bits,
  output vdr3_pkg::met_t  dn_err
);
  import vdr3_pkg::*;

  logic            valid_r;
  path_t           bits_r;
  met_t            err_r;
  logic [ST_W-1:0] best;

  assign up_ready = !valid_r || dn_ready;

  // Pick the reached end state with the lowest metric, lowest index on ties
  always_comb begin
    logic found;
    found = 1'b0;
    best  = '0;
    for (int k = 0; k < NST; k++) begin
      if (up_trel.reached[k] && (!found || up_trel.metric[k] < up_trel.metric[best])) begin
        best  = ST_W'(k);
        found = 1'b1;
      end
    end
  end

  // Hold the result until the transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      bits_r <= up_trel.path[best];
      err_r  <= up_trel.metric[best];
    end
  end

  assign dn_valid = valid_r;
  assign dn_bits  = bits_r;
  assign dn_err   = err_r;

endmodule

// ===== src/viterbi_decode_rate_third_k3.sv =====
// Hard-decision Viterbi decoder for the rate 1/3, constraint length 3 code
// (4 states, start state 00). Each 24-bit codeword (first 3-bit group in the
// top bits) runs through a row of 8 trellis cells, one add-compare-select
// step per cell, and then a final stage that picks the lowest-metric end
// state and registers the decoded 8 bits (first bit as MSB) together with
// its Hamming error count. A new codeword is taken every cycle while the
// output side keeps up, and it moves through the cell and output registers.
// Every stage holds its item while the stage after it is full and stalled.
module viterbi_decode_rate_third_k3 (
  input  logic   clk,
  input  logic   rst_n,
  vdr3_in_if.sink    in_ch,
  vdr3_out_if.source out_ch
);
  import vdr3_pkg::*;

  logic  stg_valid [MSG_BITS+1];
  logic  stg_ready [MSG_BITS+1];
  cw_t   stg_cw    [MSG_BITS+1];
  trel_t stg_trel  [MSG_BITS+1];

  // Feed the first cell with the start state only
  assign stg_valid[0]           = in_ch.valid;
  assign in_ch.ready            = stg_ready[0];
  assign stg_cw[0]              = in_ch.codeword;
  assign stg_trel[0].reached    = NST'(1);
  assign stg_trel[0].metric     = '0;
  assign stg_trel[0].path       = '0;

  // Row of trellis cells
  for (genvar g = 0; g < MSG_BITS; g++) begin : g_cell
    vdr3_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[g]),
      .up_ready (stg_ready[g]),
      .up_cw    (stg_cw[g]),
      .up_trel  (stg_trel[g]),
      .dn_valid (stg_valid[g+1]),
      .dn_ready (stg_ready[g+1]),
      .dn_cw    (stg_cw[g+1]),
      .dn_trel  (stg_trel[g+1])
    );
  end

  // End-state choice and output register
  vdr3_select u_select (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (stg_valid[MSG_BITS]),
    .up_ready (stg_ready[MSG_BITS]),
    .up_trel  (stg_trel[MSG_BITS]),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .dn_bits  (out_ch.decoded_bits),
    .dn_err   (out_ch.error_count)
  );

endmodule
